FILE: sv/mst_pkg.sv
// ----------------------------------------------------------------------------
// Timer slot table package
// Shared sizes, operation and result codes, and the item and control types
// of the timer slot table.
// ----------------------------------------------------------------------------
package mst_pkg;

   // Table geometry.
   localparam int SLOTS     = 16;
   localparam int TAG_BITS  = 16;
   localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_BITS  = $clog2(SLOTS + 1);
   localparam int TAG_W     = (TAG_BITS < 16) ? TAG_BITS : 16;
   localparam int CMP_W     = (SLOT_BITS > 4) ? SLOT_BITS : 4;

   // At most this many firings are reported for one tick item.
   localparam int MAX_RES   = 16;
   localparam int NREP_BITS = $clog2(MAX_RES + 1);

   // Operation codes of an input item.
   localparam logic [1:0] OP_TICK      = 2'd0;
   localparam logic [1:0] OP_SCHEDULE  = 2'd1;
   localparam logic [1:0] OP_UNSCH_ID  = 2'd2;
   localparam logic [1:0] OP_UNSCH_GRP = 2'd3;

   // Result kinds.
   localparam logic [2:0] K_FIRED   = 3'd0;
   localparam logic [2:0] K_SCHED   = 3'd1;
   localparam logic [2:0] K_FULL    = 3'd2;
   localparam logic [2:0] K_REMOVED = 3'd3;
   localparam logic [2:0] K_NONE    = 3'd4;

   // Payload of an input item.
   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] now_tick;
      logic [31:0] interval;
      logic [15:0] group_tag;
      logic        fire_now;
      logic        one_shot;
      logic [3:0]  timer_id;
   } req_payload_type;

   // Payload of a result item.
   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] slot_id;
      logic [4:0] removed_count;
      logic       last;
   } rsp_payload_type;

   // Command from the sequencer to the slot table.
   typedef struct packed {
      logic                 sched;
      logic                 fire;
      logic                 clear;
      logic [SLOT_BITS-1:0] idx;
   } table_cmd_type;

   // What the slot table reports for the addressed slot.
   typedef struct packed {
      logic vld;
      logic due;
      logic grp_match;
   } slot_view_type;

endpackage

FILE: sv/mst_chan_if.sv
// ----------------------------------------------------------------------------
// Timer slot table channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
interface mst_req_if;
   import mst_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface mst_rsp_if;
   import mst_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: sv/multi_slot_interval_timer_table.sv
// ----------------------------------------------------------------------------
// Multi-slot interval timer table
// Periodic and one-shot timer slots with tick, schedule and unschedule items.
// ----------------------------------------------------------------------------
// The block takes one item at a time. Every item walks the whole slot table,
// one slot per cycle through a single subtract-and-compare unit except
// while the result side holds back a waiting result, and then closes the
// item. Ready is high only between items. A tick item reports every due
// slot in slot order and gives no result when nothing fires; schedule and
// unschedule items always answer. Results pass through one output register,
// so the block finishes the current item while its final result waits to
// be taken.
module multi_slot_interval_timer_table (
   input  logic     clock,
   input  logic     reset,
   mst_req_if.sink   req_if,
   mst_rsp_if.source rsp_if
);
   import mst_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;

   localparam logic [SLOT_BITS-1:0] LAST_IDX = SLOT_BITS'(SLOTS - 1);

   // Sequencer state.
   logic [1:0]           state_ff, state_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic                 pend_vld_ff, pend_vld_in;
   rsp_payload_type      pend_ff, pend_in;
   logic [NREP_BITS-1:0] nrep_ff, nrep_in;
   logic                 hit_ff, hit_in;
   logic [SLOT_BITS-1:0] hit_slot_ff, hit_slot_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;

   // Latched fields of the current item.
   logic [1:0]       op_ff;
   logic [31:0]      now_ff;
   logic [31:0]      ival_ff;
   logic [TAG_W-1:0] grp_ff;
   logic             fire_now_ff;
   logic             one_shot_ff;
   logic [3:0]       id_ff;

   // Output register.
   logic            out_vld_ff, out_vld_in;
   rsp_payload_type out_ff, out_in;

   logic            accept;
   logic            out_free;
   logic            push;
   logic            stall;
   logic            event_hit;
   rsp_payload_type push_data;
   table_cmd_type   cmd;
   slot_view_type   view;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !out_vld_ff || rsp_if.ready;
   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.data  = out_ff;

   mst_slot_table u_table (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .now_tick    (now_ff),
      .wr_interval (ival_ff),
      .wr_group    (grp_ff),
      .wr_one_shot (one_shot_ff),
      .view        (view)
   );

   // Capture the item's fields when it is accepted.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= req_if.data.operation;
         now_ff      <= req_if.data.now_tick;
         ival_ff     <= req_if.data.interval;
         grp_ff      <= req_if.data.group_tag[TAG_W-1:0];
         fire_now_ff <= req_if.data.fire_now;
         one_shot_ff <= req_if.data.one_shot;
         id_ff       <= req_if.data.timer_id;
      end
   end

   // Per-slot event of the current operation at the scan position.
   always_comb begin
      unique case (op_ff)
         OP_TICK:      event_hit = view.vld && view.due;
         OP_SCHEDULE:  event_hit = !view.vld && !hit_ff;
         OP_UNSCH_ID:  event_hit = view.vld && (CMP_W'(id_ff) == CMP_W'(idx_ff));
         OP_UNSCH_GRP: event_hit = view.vld && view.grp_match;
         default:      event_hit = 1'b0;
      endcase
   end

   // Sequencer: one slot per unstalled scan cycle, then the closing result.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      nrep_in     = nrep_ff;
      hit_in      = hit_ff;
      hit_slot_in = hit_slot_ff;
      cnt_in      = cnt_ff;
      push        = 1'b0;
      push_data   = '0;
      stall       = 1'b0;
      cmd         = '0;
      cmd.idx     = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in    = S_SCAN;
               idx_in      = '0;
               pend_vld_in = 1'b0;
               nrep_in     = '0;
               hit_in      = 1'b0;
               cnt_in      = '0;
            end
         end

         S_SCAN: begin
            // A new firing pushes out the previous one; a scheduled slot
            // with an immediate firing reports it straight away.
            if (event_hit) begin
               if (op_ff == OP_TICK) begin
                  push      = pend_vld_ff && (nrep_ff < NREP_BITS'(MAX_RES));
                  push_data = pend_ff;
               end else if (op_ff == OP_SCHEDULE) begin
                  push      = fire_now_ff;
                  push_data = '{kind: K_FIRED, slot_id: 4'(idx_ff),
                                removed_count: 5'd0, last: 1'b0};
               end
            end
            stall = push && !out_free;

            if (!stall) begin
               if (event_hit) begin
                  unique case (op_ff)
                     OP_TICK: begin
                        cmd.fire = 1'b1;
                        if (nrep_ff < NREP_BITS'(MAX_RES)) begin
                           pend_in     = '{kind: K_FIRED, slot_id: 4'(idx_ff),
                                           removed_count: 5'd0, last: 1'b0};
                           pend_vld_in = 1'b1;
                           nrep_in     = nrep_ff + NREP_BITS'(1);
                        end
                     end
                     OP_SCHEDULE: begin
                        cmd.sched   = 1'b1;
                        hit_in      = 1'b1;
                        hit_slot_in = idx_ff;
                     end
                     OP_UNSCH_ID: begin
                        cmd.clear = 1'b1;
                        hit_in    = 1'b1;
                     end
                     OP_UNSCH_GRP: begin
                        cmd.clear = 1'b1;
                        cnt_in    = cnt_ff + CNT_BITS'(1);
                     end
                     default: begin
                        cmd.clear = 1'b0;
                     end
                  endcase
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_LAST;
               end else begin
                  idx_in = idx_ff + SLOT_BITS'(1);
               end
            end
         end

         S_LAST: begin
            // Closing result of the item, marked as the last one.
            unique case (op_ff)
               OP_TICK: begin
                  push      = pend_vld_ff;
                  push_data = pend_ff;
               end
               OP_SCHEDULE: begin
                  push      = 1'b1;
                  push_data = hit_ff ?
                     rsp_payload_type'{kind: K_SCHED, slot_id: 4'(hit_slot_ff),
                                       removed_count: 5'd0, last: 1'b0} :
                     rsp_payload_type'{kind: K_FULL, slot_id: 4'd0,
                                       removed_count: 5'd0, last: 1'b0};
               end
               OP_UNSCH_ID: begin
                  push      = 1'b1;
                  push_data = hit_ff ?
                     rsp_payload_type'{kind: K_REMOVED, slot_id: id_ff,
                                       removed_count: 5'd1, last: 1'b0} :
                     rsp_payload_type'{kind: K_NONE, slot_id: id_ff,
                                       removed_count: 5'd0, last: 1'b0};
               end
               OP_UNSCH_GRP: begin
                  push      = 1'b1;
                  push_data = (cnt_ff != '0) ?
                     rsp_payload_type'{kind: K_REMOVED, slot_id: 4'd0,
                                       removed_count: 5'(cnt_ff), last: 1'b0} :
                     rsp_payload_type'{kind: K_NONE, slot_id: 4'd0,
                                       removed_count: 5'd0, last: 1'b0};
               end
               default: begin
                  push = 1'b0;
               end
            endcase
            push_data.last = 1'b1;
            stall = push && !out_free;
            if (!stall) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads a result when empty or being emptied.
   always_comb begin
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_if.ready;
      if (push && out_free) begin
         out_in     = push_data;
         out_vld_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         idx_ff      <= '0;
         pend_vld_ff <= 1'b0;
         nrep_ff     <= '0;
         hit_ff      <= 1'b0;
         cnt_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         pend_vld_ff <= pend_vld_in;
         nrep_ff     <= nrep_in;
         hit_ff      <= hit_in;
         cnt_ff      <= cnt_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      hit_slot_ff <= hit_slot_in;
      out_ff      <= out_in;
   end

   // A scheduled result always closes its item.
   a_sched_last: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (out_ff.kind == K_SCHED)) |-> out_ff.last)
      else $error("scheduled result without last flag");

   // The report count never passes the per-tick limit.
   a_nrep_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> nrep_ff <= NREP_BITS'(MAX_RES))
      else $error("too many firings reported");

   // An unstalled scan cycle moves on by exactly one slot.
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !stall && idx_ff != LAST_IDX)
      |=> idx_ff == $past(idx_ff) + SLOT_BITS'(1))
      else $error("scan index skipped a slot");

   // An accepted item starts its scan at the first slot.
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN && idx_ff == '0 && !pend_vld_ff))
      else $error("scan did not start cleanly");

endmodule

FILE: sv/mst_slot_table.sv
// ----------------------------------------------------------------------------
// Timer slot table storage
// Holds the slot entries and evaluates one addressed slot per cycle with a
// single subtract and compare unit.
// ----------------------------------------------------------------------------
module mst_slot_table (
   input  logic                  clock,
   input  logic                  reset,
   input  mst_pkg::table_cmd_type cmd,
   input  logic [31:0]           now_tick,
   input  logic [31:0]           wr_interval,
   input  logic [mst_pkg::TAG_W-1:0] wr_group,
   input  logic                  wr_one_shot,
   output mst_pkg::slot_view_type view
);
   import mst_pkg::*;

   logic [SLOTS-1:0] valid_ff;
   logic [SLOTS-1:0] valid_in;
   logic [31:0]      interval_ff [SLOTS];
   logic [31:0]      last_fire_ff [SLOTS];
   logic             one_shot_ff [SLOTS];
   logic [TAG_W-1:0] group_ff [SLOTS];

   logic [31:0]      rd_interval;
   logic [31:0]      rd_elapsed;

   // Due check for the addressed slot: elapsed time wraps modulo 2^32.
   always_comb begin
      rd_interval   = interval_ff[cmd.idx];
      rd_elapsed    = now_tick - last_fire_ff[cmd.idx];
      view.vld      = valid_ff[cmd.idx];
      view.due      = (rd_interval == 32'd0) ||
                      ((now_tick != 32'd0) && (rd_elapsed > rd_interval));
      view.grp_match = (group_ff[cmd.idx] == wr_group);
   end

   // Valid bits: set by a schedule, cleared by removal or a one-shot firing.
   always_comb begin
      valid_in = valid_ff;
      if (cmd.sched) begin
         valid_in[cmd.idx] = 1'b1;
      end else if (cmd.clear || (cmd.fire && one_shot_ff[cmd.idx])) begin
         valid_in[cmd.idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Slot entries are written only on a schedule or a firing.
   always_ff @(posedge clock) begin
      if (cmd.sched) begin
         interval_ff[cmd.idx]  <= wr_interval;
         last_fire_ff[cmd.idx] <= 32'd0;
         one_shot_ff[cmd.idx]  <= wr_one_shot;
         group_ff[cmd.idx]     <= wr_group;
      end else if (cmd.fire) begin
         last_fire_ff[cmd.idx] <= now_tick;
      end
   end

endmodule
